@@ hw/rtl/ima_enc_pkg.sv @@
`default_nettype none
package ima_enc_pkg;

  localparam int CHANNELS   = 2;
  localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MAX_INDEX  = 88;

  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic signed [17:0] PRED_MAX = 18'sd32767;
  localparam logic signed [17:0] PRED_MIN = -18'sd32767;

  localparam logic [14:0] STEP_TABLE [0:MAX_INDEX] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,    15'd14,
    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,    15'd31,
    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
    15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,   15'd130,   15'd143,
    15'd157,   15'd173,   15'd190,   15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
    15'd337,   15'd371,   15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
    15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,  15'd3024,
    15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
    15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  // Index adjustment by code magnitude, sign-extended to 5 bits.
  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    case (mag)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

  typedef struct packed {
    logic [3:0]         code;
    logic signed [15:0] pred_next;
    logic [6:0]         index_next;
  } ima_enc_quant_t;

  // Up to four result bytes of one transaction, byte 0 is sent first.
  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][7:0] bytes;
  } ima_enc_burst_t;

endpackage
`default_nettype wire

@@ hw/rtl/ima_enc_quant.sv @@
`default_nettype none
module ima_enc_quant (
  input  wire logic signed [15:0] sample,
  input  wire logic signed [15:0] pred,
  input  wire logic [6:0]         index,
  output ima_enc_pkg::ima_enc_quant_t result
);

  logic [6:0]         idx_c;
  logic [14:0]        step;
  logic signed [16:0] diff;
  logic               neg;
  logic [16:0]        mag0, mag1, mag2;
  logic [16:0]        s2, s1, s0;
  logic               b2, b1, b0;
  logic [16:0]        recon;
  logic signed [17:0] pred_wide;
  logic signed [7:0]  ni;

  always_comb begin
    idx_c = (index > 7'(ima_enc_pkg::MAX_INDEX)) ? 7'(ima_enc_pkg::MAX_INDEX) : index;
    step  = ima_enc_pkg::STEP_TABLE[idx_c];
    diff  = {sample[15], sample} - {pred[15], pred};
    neg   = diff[16];
    mag0  = neg ? 17'(-diff) : 17'(diff);

    s2 = {2'b00, step};
    s1 = {3'b000, step[14:1]};
    s0 = {4'b0000, step[14:2]};

    // Three compare steps against step, step/2 and step/4; the first two also subtract.
    b2   = (mag0 >= s2);
    mag1 = b2 ? (mag0 - s2) : mag0;
    b1   = (mag1 >= s1);
    mag2 = b1 ? (mag1 - s1) : mag1;
    b0   = (mag2 >= s0);

    recon = {5'b00000, step[14:3]} + (b2 ? s2 : 17'd0) + (b1 ? s1 : 17'd0)
          + (b0 ? s0 : 17'd0);

    pred_wide = neg ? ({{2{pred[15]}}, pred} - $signed({1'b0, recon}))
                    : ({{2{pred[15]}}, pred} + $signed({1'b0, recon}));

    if (pred_wide > ima_enc_pkg::PRED_MAX) begin
      result.pred_next = 16'(ima_enc_pkg::PRED_MAX);
    end else if (pred_wide < ima_enc_pkg::PRED_MIN) begin
      result.pred_next = 16'(ima_enc_pkg::PRED_MIN);
    end else begin
      result.pred_next = pred_wide[15:0];
    end

    ni = $signed({1'b0, idx_c}) + 8'(ima_enc_pkg::index_adjust({b2, b1, b0}));
    if (ni < 8'sd0) begin
      result.index_next = 7'd0;
    end else if (ni > 8'(ima_enc_pkg::MAX_INDEX)) begin
      result.index_next = 7'(ima_enc_pkg::MAX_INDEX);
    end else begin
      result.index_next = ni[6:0];
    end

    result.code = {neg, b2, b1, b0};
  end

endmodule
`default_nettype wire

@@ hw/rtl/ima_enc_outbuf.sv @@
`default_nettype none
module ima_enc_outbuf (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire ima_enc_pkg::ima_enc_burst_t burst,
  output logic                             can_load,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata,   // out_byte[7:0]
  output logic                             m_tlast
);

  logic [3:0][7:0] bytes;
  logic [1:0]      ptr;
  logic [2:0]      count;
  logic            pop;

  assign m_tvalid = (count != 3'd0);
  assign m_tdata  = bytes[ptr];
  assign m_tlast  = (count == 3'd1);
  assign pop      = m_tvalid && m_tready;
  assign can_load = (count == 3'd0) || ((count == 3'd1) && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= 2'd0;
      count <= 3'd0;
    end else if (load) begin
      bytes <= burst.bytes;
      ptr   <= 2'd0;
      count <= burst.count;
    end else if (pop) begin
      ptr   <= ptr + 2'd1;
      count <= count - 3'd1;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> ((count == 3'd0) || ((count == 3'd1) && m_tready)))
    else $error("output buffer loaded while bytes are still pending");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (count != 3'd0) |-> (({2'b00, ptr} + {1'b0, count}) <= 4'd4))
    else $error("output buffer read pointer runs past the last byte");

  a_drains_empty: assert property (@(posedge clk) disable iff (rst)
    (pop && (count == 3'd1) && !load) |=> !m_tvalid)
    else $error("output buffer still valid after its last byte was taken");

endmodule
`default_nettype wire

@@ hw/rtl/ima_adpcm_block_encoder_core.sv @@
`default_nettype none
// Channel | Direction | Handshake          | Payload
// s_*     | in        | s_tvalid/s_tready  | s_tdata = pcm_sample, s_tuser = func, chan
// m_*     | out       | m_tvalid/m_tready  | m_tdata = out_byte, m_tlast = last_of_run
//
// Each transaction is captured in an input register; from there the quantizer and the
// channel state update run in one pass and the result bytes go into the output buffer.
// A sample transaction is accepted every cycle unless its byte finds the output buffer busy; a
// header loads four bytes, and the output buffer sends one byte per cycle while m_tready is high.
// Reset clears all channel state and empties both registers.
// A stalled output holds the input register once the buffer cannot take the next bytes.
module ima_adpcm_block_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // pcm_sample[15:0]
  input  wire logic [3:0]  s_tuser,   // func[0], chan[3:1]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte[7:0]
  output logic             m_tlast
);

  localparam int CH  = ima_enc_pkg::CHANNELS;
  localparam int CIW = ima_enc_pkg::CHAN_IDX_W;

  logic               in_valid;
  logic               func_q;
  logic [2:0]         chan_q;
  logic signed [15:0] sample_q;

  logic signed [15:0] pred_st  [CH];
  logic [6:0]         index_st [CH];
  logic [3:0]         pend_st  [CH];
  logic               phase_st [CH];

  logic [CIW-1:0]              ch;
  logic                        chan_ok;
  ima_enc_pkg::ima_enc_quant_t qres;
  ima_enc_pkg::ima_enc_burst_t burst;
  logic                        can_load;
  logic                        advance;
  logic                        load;

  assign ch      = chan_q[CIW-1:0];
  assign chan_ok = ({1'b0, chan_q} < 4'(CH));

  ima_enc_quant u_quant (
    .sample (sample_q),
    .pred   (pred_st[ch]),
    .index  (index_st[ch]),
    .result (qres)
  );

  always_comb begin
    burst.bytes = '0;
    burst.count = 3'd0;
    if (chan_ok) begin
      if (func_q == ima_enc_pkg::FUNC_HEADER) begin
        burst.bytes[0] = pred_st[ch][7:0];
        burst.bytes[1] = pred_st[ch][15:8];
        burst.bytes[2] = {1'b0, index_st[ch]};
        burst.bytes[3] = 8'h00;
        burst.count    = 3'd4;
      end else if (phase_st[ch]) begin
        burst.bytes[0] = {qres.code, pend_st[ch]};
        burst.count    = 3'd1;
      end
    end
  end

  // A transaction that yields no byte never waits for the output side.
  assign advance  = in_valid && ((burst.count == 3'd0) || can_load);
  assign load     = advance && (burst.count != 3'd0);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      for (int i = 0; i < CH; i++) begin
        pred_st[i]  <= '0;
        index_st[i] <= '0;
        pend_st[i]  <= '0;
        phase_st[i] <= 1'b0;
      end
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
        func_q   <= s_tuser[0];
        chan_q   <= s_tuser[3:1];
        sample_q <= s_tdata;
      end
      if (advance && chan_ok) begin
        if (func_q == ima_enc_pkg::FUNC_HEADER) begin
          pend_st[ch]  <= 4'd0;
          phase_st[ch] <= 1'b0;
        end else begin
          pred_st[ch]  <= qres.pred_next;
          index_st[ch] <= qres.index_next;
          pend_st[ch]  <= phase_st[ch] ? 4'd0 : qres.code;
          phase_st[ch] <= !phase_st[ch];
        end
      end
    end
  end

  ima_enc_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .burst    (burst),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(chan_q) && $stable(func_q)))
    else $error("input register changed while its transaction was waiting");

  a_bad_channel_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !chan_ok) |-> (burst.count == 3'd0))
    else $error("out-of-range channel produced output bytes");

  a_header_four_bytes: assert property (@(posedge clk) disable iff (rst)
    (advance && chan_ok && (func_q == ima_enc_pkg::FUNC_HEADER)) |-> load)
    else $error("header transaction advanced without loading its bytes");

endmodule
`default_nettype wire
